@@ design/flash_download_session_fsm_macros.svh @@
// ----------------------------------------------------------------------------
// flash download session assertion macros
// shared concurrent assertion forms, clocked on i_clk, gated by reset
// ----------------------------------------------------------------------------
`ifndef FLASH_DOWNLOAD_SESSION_FSM_MACROS_SVH
`define FLASH_DOWNLOAD_SESSION_FSM_MACROS_SVH

// condition holds at every clock edge out of reset
`define FDSF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define FDSF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/fdsf_pkg.sv @@
// ----------------------------------------------------------------------------
// fdsf_pkg
// shared types, codes and crc helper of the flash download session block
// ----------------------------------------------------------------------------
package fdsf_pkg;

    localparam int PAGE_BYTES_DEF = 128;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] SVC_SESSION  = 8'h10;
    localparam logic [7:0] SVC_DOWNLOAD = 8'h34;
    localparam logic [7:0] SVC_TRANSFER = 8'h36;
    localparam logic [7:0] SVC_EXIT     = 8'h37;
    localparam logic [7:0] RESP_NEG     = 8'h7F;
    localparam logic [7:0] RESP_OFS     = 8'h40;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam logic [1:0] CFG_MAX_SIZE = 2'd0;
    localparam logic [1:0] CFG_CRC_CODE = 2'd1;
    localparam logic [1:0] CFG_SUBCODE  = 2'd2;

    localparam logic KIND_RESP  = 1'b0;
    localparam logic KIND_FLASH = 1'b1;

    typedef enum logic [2:0] {
        ST_SESSION  = 3'd0,
        ST_DOWNLOAD = 3'd1,
        ST_TRANSFER = 3'd2,
        ST_EXIT     = 3'd3,
        ST_CHECK    = 3'd4
    } t_sess_state;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  resp_byte;
        logic [14:0] flash_addr;
        logic [7:0]  flash_byte;
        logic        start_app;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] size_limit;
        logic [7:0]  crc_check_code;
        logic [7:0]  session_subcode;
    } t_cfg;

    // crc-16 reflected, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/fdsf_front.sv @@
// ----------------------------------------------------------------------------
// fdsf_front
// frames incoming bytes, runs the session sequence and builds result items
// ----------------------------------------------------------------------------
module fdsf_front #(
    parameter int PAGE_BYTES = fdsf_pkg::PAGE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  fdsf_pkg::t_in_item i_item,
    input  fdsf_pkg::t_cfg     i_cfg,
    output logic [1:0]         o_wr_cnt,
    output fdsf_pkg::t_out_item o_res0,
    output fdsf_pkg::t_out_item o_res1
);

    localparam logic [7:0]  XFER_LEN  = 8'(PAGE_BYTES + 1);
    localparam logic [15:0] PAGE_INC  = 16'(PAGE_BYTES);
    localparam logic [14:0] PAGE_MULT = 15'(PAGE_BYTES);

    logic                  r_busy, n_busy;
    logic [7:0]            r_len, n_len;
    logic [7:0]            r_idx, n_idx;
    logic [7:0]            r_svc, n_svc;
    logic [15:0]           r_pw, n_pw;
    logic                  r_ta, n_ta;
    fdsf_pkg::t_sess_state r_sess, n_sess;
    logic [15:0]           r_size, n_size;
    logic [15:0]           r_recv, n_recv;
    logic [7:0]            r_page, n_page;
    logic [15:0]           r_crc, n_crc;

    logic        flash_hit;
    logic        resp_hit;
    logic [7:0]  resp_code;
    logic        resp_start;
    logic [7:0]  idx_inc;
    logic [15:0] recv_inc;

    assign idx_inc  = r_idx + 8'd1;
    assign recv_inc = r_recv + PAGE_INC;

    // next state of framing and session
    always_comb begin
        logic [7:0]  svc_v;
        logic [15:0] pw_v;
        logic        ta_v;
        n_busy = r_busy; n_len = r_len; n_idx = r_idx; n_svc = r_svc;
        n_pw = r_pw; n_ta = r_ta; n_sess = r_sess; n_size = r_size;
        n_recv = r_recv; n_page = r_page; n_crc = r_crc;
        flash_hit = 1'b0; resp_hit = 1'b0;
        resp_code = fdsf_pkg::RESP_NEG; resp_start = 1'b0;
        svc_v = r_svc; pw_v = r_pw; ta_v = r_ta;
        if (i_accept) begin
            if (i_item.func) begin
                n_svc = fdsf_pkg::SVC_SESSION;
                n_sess = fdsf_pkg::ST_DOWNLOAD;
                resp_hit = 1'b1;
                resp_code = fdsf_pkg::SVC_SESSION + fdsf_pkg::RESP_OFS;
            end else if (!r_busy) begin
                if (i_item.rx_byte != 8'd0) begin
                    n_len = i_item.rx_byte;
                    n_idx = 8'd0;
                    n_busy = 1'b1;
                end
            end else begin
                if (r_idx == 8'd0) begin
                    svc_v = i_item.rx_byte;
                    pw_v = 16'd0;
                    ta_v = (i_item.rx_byte == fdsf_pkg::SVC_TRANSFER)
                        && (r_sess == fdsf_pkg::ST_TRANSFER) && (r_len == XFER_LEN);
                end else begin
                    pw_v = {r_pw[7:0], i_item.rx_byte};
                    if (r_ta) begin
                        flash_hit = 1'b1;
                        n_crc = fdsf_pkg::crc_update(r_crc, i_item.rx_byte);
                    end
                end
                n_svc = svc_v; n_pw = pw_v; n_ta = ta_v; n_idx = idx_inc;
                if (idx_inc == r_len) begin
                    n_busy = 1'b0;
                    n_idx = 8'd0;
                    n_ta = 1'b0;
                    resp_hit = 1'b1;
                    n_sess = fdsf_pkg::ST_SESSION;
                    priority if (svc_v == fdsf_pkg::SVC_SESSION) begin
                        if (r_len == 8'd2 && pw_v[7:0] == i_cfg.session_subcode
                            && r_sess == fdsf_pkg::ST_SESSION) begin
                            n_sess = fdsf_pkg::ST_DOWNLOAD;
                            resp_code = svc_v + fdsf_pkg::RESP_OFS;
                        end
                    end else if (svc_v == fdsf_pkg::SVC_DOWNLOAD) begin
                        if (r_sess == fdsf_pkg::ST_DOWNLOAD && r_len == 8'd3
                            && pw_v < i_cfg.size_limit) begin
                            n_size = pw_v; n_recv = 16'd0; n_page = 8'd0;
                            n_crc = fdsf_pkg::CRC_INIT;
                            n_sess = fdsf_pkg::ST_TRANSFER;
                            resp_code = svc_v + fdsf_pkg::RESP_OFS;
                        end
                    end else if (svc_v == fdsf_pkg::SVC_TRANSFER) begin
                        if (ta_v) begin
                            n_page = r_page + 8'd1;
                            n_recv = recv_inc;
                            n_sess = (recv_inc == r_size) ? fdsf_pkg::ST_EXIT : r_sess;
                            resp_code = svc_v + fdsf_pkg::RESP_OFS;
                        end
                    end else if (svc_v == fdsf_pkg::SVC_EXIT) begin
                        if (r_sess == fdsf_pkg::ST_EXIT && r_len == 8'd1) begin
                            n_sess = fdsf_pkg::ST_CHECK;
                            resp_code = svc_v + fdsf_pkg::RESP_OFS;
                        end
                    end else if (svc_v == i_cfg.crc_check_code) begin
                        if (r_sess == fdsf_pkg::ST_CHECK && r_len == 8'd3
                            && pw_v == n_crc) begin
                            resp_start = 1'b1;
                            resp_code = svc_v + fdsf_pkg::RESP_OFS;
                        end
                    end else begin
                        resp_code = fdsf_pkg::RESP_NEG;
                    end
                end
            end
        end
    end

    // result items toward the queue
    always_comb begin
        fdsf_pkg::t_out_item flash_item;
        fdsf_pkg::t_out_item resp_item;
        flash_item.kind       = fdsf_pkg::KIND_FLASH;
        flash_item.resp_byte  = 8'd0;
        flash_item.flash_addr = 15'({7'd0, r_page} * PAGE_MULT) + 15'(r_idx - 8'd1);
        flash_item.flash_byte = i_item.rx_byte;
        flash_item.start_app  = 1'b0;
        flash_item.last       = !resp_hit;
        resp_item.kind        = fdsf_pkg::KIND_RESP;
        resp_item.resp_byte   = resp_code;
        resp_item.flash_addr  = 15'd0;
        resp_item.flash_byte  = 8'd0;
        resp_item.start_app   = resp_start;
        resp_item.last        = 1'b1;
        o_res0 = flash_hit ? flash_item : resp_item;
        o_res1 = resp_item;
        o_wr_cnt = 2'({1'b0, flash_hit} + {1'b0, resp_hit});
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_len <= 8'd0; r_idx <= 8'd0; r_svc <= 8'd0;
            r_pw <= 16'd0; r_ta <= 1'b0; r_sess <= fdsf_pkg::ST_SESSION;
            r_size <= 16'd0; r_recv <= 16'd0; r_page <= 8'd0;
            r_crc <= fdsf_pkg::CRC_INIT;
        end else begin
            r_busy <= n_busy; r_len <= n_len; r_idx <= n_idx; r_svc <= n_svc;
            r_pw <= n_pw; r_ta <= n_ta; r_sess <= n_sess;
            r_size <= n_size; r_recv <= n_recv; r_page <= n_page; r_crc <= n_crc;
        end
    end

endmodule

@@ design/fdsf_queue.sv @@
// ----------------------------------------------------------------------------
// fdsf_queue
// result queue, takes up to two items a cycle, hands out one
// ----------------------------------------------------------------------------
module fdsf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_wr_cnt,
    input  fdsf_pkg::t_out_item i_res0,
    input  fdsf_pkg::t_out_item i_res1,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output fdsf_pkg::t_out_item o_head
);

    localparam int PW = $clog2(fdsf_pkg::QUEUE_DEPTH);

    fdsf_pkg::t_out_item r_mem [fdsf_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          rd;
    logic [PW-1:0] wp1;

    assign o_empty = (r_cnt == '0);
    // room for two items needed before taking the next input
    assign o_full  = (r_cnt > (PW+1)'(fdsf_pkg::QUEUE_DEPTH - 2));
    assign o_head  = r_mem[r_rp];
    assign rd      = i_pop && !o_empty;
    assign wp1     = r_wp + 1'b1;

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) r_mem[r_wp] <= i_res0;
        if (i_wr_cnt == 2'd2) r_mem[wp1] <= i_res1;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_wr_cnt);
            r_rp  <= r_rp + PW'(rd);
            r_cnt <= r_cnt + (PW+1)'(i_wr_cnt) - (PW+1)'(rd);
        end
    end

endmodule

@@ design/flash_download_session_fsm.sv @@
// a result is built from its taken input byte and registered into the result queue before it reaches the queue head
// throughput: one byte per cycle; a byte yields at most two results, drained one a cycle
// the front stalls only when the four-entry result queue lacks room for two results
// reset: synchronous active low; session waits for programming session, crc = 0xFFFF
// configuration resets to max size 28672, check code 0x31, session subcode 0x03
// ----------------------------------------------------------------------------
// flash_download_session_fsm
// top level: configuration registers, request front end and result queue
// ----------------------------------------------------------------------------
`include "flash_download_session_fsm_macros.svh"

module flash_download_session_fsm #(
    parameter int PAGE_BYTES = fdsf_pkg::PAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  fdsf_pkg::t_in_item  i_in,
    output logic                o_empty,
    input  logic                i_pop,
    output fdsf_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    fdsf_pkg::t_cfg      r_cfg;
    fdsf_pkg::t_out_item res0, res1;
    logic [1:0]          wr_cnt;
    logic                in_acc;

    assign o_cfg_ready = 1'b1;
    assign in_acc = i_push && !o_full;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_limit      <= 16'd28672;
            r_cfg.crc_check_code  <= 8'd49;
            r_cfg.session_subcode <= 8'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fdsf_pkg::CFG_MAX_SIZE: r_cfg.size_limit      <= i_cfg_data;
                fdsf_pkg::CFG_CRC_CODE: r_cfg.crc_check_code  <= i_cfg_data[7:0];
                fdsf_pkg::CFG_SUBCODE:  r_cfg.session_subcode <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // request front end
    fdsf_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(in_acc), .i_item(i_in),
        .i_cfg(r_cfg), .o_wr_cnt(wr_cnt), .o_res0(res0), .o_res1(res1)
    );

    // result queue
    fdsf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_cnt(wr_cnt), .i_res0(res0),
        .i_res1(res1), .i_pop(i_pop), .o_full(o_full), .o_empty(o_empty),
        .o_head(o_out)
    );

    // checks
    `FDSF_ASSERT_ALWAYS(a_wr_needs_accept, (wr_cnt == 2'd0) || in_acc, "result without accepted transaction")
    `FDSF_ASSERT_ALWAYS(a_start_on_resp, o_empty || !o_out.start_app || (o_out.kind == fdsf_pkg::KIND_RESP && o_out.last), "start_app off a final response")
    `FDSF_ASSERT_ALWAYS(a_flash_clean, o_empty || o_out.kind == fdsf_pkg::KIND_RESP || o_out.resp_byte == 8'd0, "flash write carries a response code")

endmodule
